>>> hdl/ilid_pkg.sv
// ilid_pkg: shared types and codes for the indexed list block
`default_nettype none
package ilid_pkg;

	// field widths
	localparam int KIND_W  = 3;
	localparam int POS_W   = 7;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;
	localparam int STAT_W  = 2;

	// packed stream widths, filled up to whole bytes
	localparam int IN_DATA_W  = 40;
	localparam int OUT_DATA_W = 48;
	localparam int OUT_PAD_W  = OUT_DATA_W - STAT_W - VALUE_W - COUNT_W;

	// operation codes
	localparam logic [KIND_W-1:0] KIND_INS_AT    = 3'd0;
	localparam logic [KIND_W-1:0] KIND_INS_END   = 3'd1;
	localparam logic [KIND_W-1:0] KIND_DEL_AT    = 3'd2;
	localparam logic [KIND_W-1:0] KIND_DEL_END   = 3'd3;
	localparam logic [KIND_W-1:0] KIND_TRAVERSE  = 3'd4;

	// result status codes
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [STAT_W-1:0] ST_FULL      = 2'd2;
	localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

	typedef logic signed [VALUE_W-1:0] value_t;
	typedef logic [COUNT_W-1:0] count_t;

	// controller to datapath
	typedef struct packed {
		logic load;  // capture the input transaction
		logic step;  // execute one step and load the output register
	} ilid_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic out_free;   // output register empty or being taken
		logic step_last;  // the current step gives the final result
	} ilid_sts_t;

endpackage
`default_nettype wire

>>> hdl/ilid_ctrl.sv
// ilid_ctrl: controller state machine for the indexed list block
`default_nettype none
module ilid_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire ilid_pkg::ilid_sts_t sts,
	output ilid_pkg::ilid_cmd_t    cmd
);
	import ilid_pkg::*;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic state_q;
	logic state_d;

	// handshake and commands
	always_comb begin
		s_tready = (state_q == S_IDLE);
		cmd.load = (state_q == S_IDLE) && s_tvalid;
		cmd.step = (state_q == S_EXEC) && sts.out_free;
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.load) state_d = S_EXEC;
			end
			S_EXEC: begin
				if (cmd.step && sts.step_last) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

>>> hdl/ilid_dp.sv
// ilid_dp: list cells, element count, operation decode and output register
`default_nettype none
module ilid_dp #(
	parameter int CAPACITY = 8
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ilid_pkg::ilid_cmd_t               cmd,
	output ilid_pkg::ilid_sts_t                    sts,
	input  wire logic [ilid_pkg::KIND_W-1:0]       in_kind,
	input  wire logic [ilid_pkg::POS_W-1:0]        in_position,
	input  wire logic signed [ilid_pkg::VALUE_W-1:0] in_item_value,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic [ilid_pkg::STAT_W-1:0]            out_status,
	output logic signed [ilid_pkg::VALUE_W-1:0]    out_read_value,
	output logic [ilid_pkg::COUNT_W-1:0]           out_element_count,
	output logic                                   out_last
);
	import ilid_pkg::*;

	localparam count_t CAP_C = COUNT_W'(CAPACITY);

	// captured operation
	logic [KIND_W-1:0] kind_q;
	logic [POS_W-1:0]  pos_q;
	value_t            val_q;

	// list state
	value_t slots_q [CAPACITY];
	value_t slots_d [CAPACITY];
	count_t count_q;
	count_t count_d;
	count_t trav_idx_q;
	count_t count_m1;

	// operation decode
	logic [STAT_W-1:0] status_c;
	logic [POS_W-1:0]  ins_pos;
	logic [POS_W-1:0]  del_pos;
	logic              ins_go;
	logic              del_go;
	logic              rot_go;
	logic              is_trav;
	logic              trav_last;
	logic              last_c;
	value_t            rdval_c;

	// output register
	logic              ov_q;
	logic [STAT_W-1:0] ost_q;
	value_t            oval_q;
	count_t            ocnt_q;
	logic              olast_q;

	assign count_m1  = count_q - 1'b1;
	assign is_trav   = (kind_q == KIND_TRAVERSE);
	assign trav_last = (trav_idx_q == count_m1);
	assign ins_pos   = (kind_q == KIND_INS_END) ? count_q : pos_q;
	assign del_pos   = (kind_q == KIND_DEL_END) ? count_m1 : pos_q;

	// status and result decode for the captured operation
	always_comb begin
		status_c = ST_OK;
		ins_go   = 1'b0;
		del_go   = 1'b0;
		rot_go   = 1'b0;
		last_c   = 1'b1;
		rdval_c  = '0;
		case (kind_q)
			KIND_INS_AT, KIND_INS_END: begin
				if (ins_pos > count_q) status_c = ST_BAD_INDEX;
				else if (count_q >= CAP_C) status_c = ST_FULL;
				else ins_go = 1'b1;
			end
			KIND_DEL_AT: begin
				if (pos_q > count_q) status_c = ST_BAD_INDEX;
				else if (count_q == '0) status_c = ST_EMPTY;
				else if (pos_q == count_q) status_c = ST_BAD_INDEX;
				else del_go = 1'b1;
			end
			KIND_DEL_END: begin
				if (count_q == '0) status_c = ST_EMPTY;
				else del_go = 1'b1;
			end
			KIND_TRAVERSE: begin
				if (count_q == '0) begin
					status_c = ST_EMPTY;
				end else begin
					rot_go  = 1'b1;
					rdval_c = slots_q[0];
					last_c  = trav_last;
				end
			end
			default: status_c = ST_OK;
		endcase
	end

	// new element count
	always_comb begin
		count_d = count_q;
		if (ins_go) count_d = count_q + 1'b1;
		else if (del_go) count_d = count_m1;
	end

	// one cell per slot: shift right on insert, left on delete, rotate on traverse
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		localparam count_t IDX = COUNT_W'(i);
		value_t left_nb;
		value_t right_nb;

		if (i == 0) begin : g_first
			assign left_nb = '0;
		end else begin : g_mid_l
			assign left_nb = slots_q[i-1];
		end
		if (i == CAPACITY - 1) begin : g_end
			assign right_nb = '0;
		end else begin : g_mid_r
			assign right_nb = slots_q[i+1];
		end

		always_comb begin
			slots_d[i] = slots_q[i];
			if (ins_go) begin
				if (IDX == ins_pos) slots_d[i] = val_q;
				else if (IDX > ins_pos && IDX <= count_q) slots_d[i] = left_nb;
			end else if (del_go) begin
				if (IDX >= del_pos && IDX < count_m1) slots_d[i] = right_nb;
				else if (IDX == count_m1) slots_d[i] = '0;
			end else if (rot_go) begin
				if (IDX == count_m1) slots_d[i] = slots_q[0];
				else if (IDX < count_m1) slots_d[i] = right_nb;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				slots_q[i] <= '0;
			end else if (cmd.step) begin
				slots_q[i] <= slots_d[i];
			end
		end
	end

	// capture of the input transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= in_kind;
			pos_q  <= in_position;
			val_q  <= in_item_value;
		end
	end

	// count and traverse index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			trav_idx_q <= '0;
		end else begin
			if (cmd.step) count_q <= count_d;
			if (cmd.load || (cmd.step && last_c)) trav_idx_q <= '0;
			else if (cmd.step) trav_idx_q <= trav_idx_q + 1'b1;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.step) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (cmd.step) begin
			ost_q   <= status_c;
			oval_q  <= rdval_c;
			ocnt_q  <= count_d;
			olast_q <= last_c;
		end
	end

	assign sts.out_free      = !ov_q || out_ready;
	assign sts.step_last     = last_c;
	assign out_valid         = ov_q;
	assign out_status        = ost_q;
	assign out_read_value    = oval_q;
	assign out_element_count = ocnt_q;
	assign out_last          = olast_q;

	// the count never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_C)
		else $error("element count above capacity");

	// a traverse step that is not the last leaves the count alone
	a_trav_count: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && is_trav && !last_c) |=> $stable(count_q))
		else $error("count changed during traverse");

	// a successful insert grows the list by one
	a_ins_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && ins_go) |=> (count_q == $past(count_q) + 1'b1))
		else $error("insert did not grow the list");

	// every step refills the output register
	a_step_fill: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> ov_q)
		else $error("output register empty after a step");

endmodule
`default_nettype wire

>>> hdl/indexed_list_insert_delete.sv
// indexed_list_insert_delete: top level of the indexed list block
//
// channel  direction  handshake          payload
// s        in         s_tvalid/s_tready  s_tuser kind, s_tdata position, item_value
// m        out        m_tvalid/m_tready  m_tdata status, read_value, element_count; m_tlast
//
// insert, delete and unused kinds need a capture, then one execute step
// traverse needs a capture, then one execute step per element (one on an empty list), one value per step via slot 0
// a stalled result holds the execute step and s_tready stays low until the final step
// the next transaction is taken while the final result of the previous one waits
// reset clears the list cells and the count at once, no clearing pass
`default_nettype none
module indexed_list_insert_delete #(
	parameter int CAPACITY = 8
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,   // position[6:0], item_value[38:7], zero[39]
	input  wire logic [2:0]  s_tuser,   // kind[2:0]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // status[1:0], read_value[33:2],
	                                    // element_count[40:34], zero[47:41]
	output logic             m_tlast
);
	import ilid_pkg::*;

	ilid_cmd_t         cmd;
	ilid_sts_t         sts;
	logic [STAT_W-1:0] status;
	value_t            read_value;
	count_t            element_count;

	// sequencing
	ilid_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// list storage and result register
	ilid_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk               (clk),
		.arst_n            (arst_n),
		.cmd               (cmd),
		.sts               (sts),
		.in_kind           (s_tuser),
		.in_position       (s_tdata[POS_W-1:0]),
		.in_item_value     (s_tdata[POS_W+VALUE_W-1:POS_W]),
		.out_valid         (m_tvalid),
		.out_ready         (m_tready),
		.out_status        (status),
		.out_read_value    (read_value),
		.out_element_count (element_count),
		.out_last          (m_tlast)
	);

	// result packing
	assign m_tdata = {{OUT_PAD_W{1'b0}}, element_count, read_value, status};

endmodule
`default_nettype wire
